/* rtl/core/sbe_pkg.sv */
// types, constants and the microprogram of the stack bytecode executor
// depends on nothing; used by the sequencer, the top level and the checker
package sbe_pkg;

    localparam int WORD_BYTES = 4;
    localparam int SP_W       = 8;
    localparam int CNT_W      = 6;
    localparam int UPC_W      = 6;

    // instruction codes
    typedef enum logic [2:0] {
        CMD_LIT,
        CMD_LOAD,
        CMD_STORE,
        CMD_ADD,
        CMD_SUB,
        CMD_PCHR,
        CMD_PINT,
        CMD_NL
    } cmd_t;

    // result kinds
    typedef enum logic [1:0] {
        K_ACK,
        K_CHAR,
        K_INT,
        K_NL
    } kind_t;

    // error codes
    typedef enum logic [1:0] {
        E_OK,
        E_OVF,
        E_UNF,
        E_ADDR
    } err_t;

    // sequencing of one microstep
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_NEXT,
        SQ_LOOP,
        SQ_FAIL,
        SQ_SKIP,
        SQ_DONE,
        SQ_CHAR
    } seq_op_t;

    // tested conditions
    typedef enum logic [2:0] {
        CD_NONE,
        CD_OVF,
        CD_UND1,
        CD_UND2,
        CD_ADDR,
        CD_COUNT,
        CD_ZERO
    } cond_t;

    typedef enum logic [1:0] {
        MO_NONE,
        MO_RD,
        MO_WR
    } mem_op_t;

    // byte address sources
    typedef enum logic [2:0] {
        AS_SP,
        AS_SPM4,
        AS_SPP4,
        AS_TGT,
        AS_PTR
    } addr_sel_t;

    // register loads, taken on the first cycle of a step
    typedef enum logic [2:0] {
        LD_NONE,
        LD_TGT,
        LD_WORD,
        LD_ALU,
        LD_B,
        LD_CNT
    } ld_t;

    typedef enum logic [2:0] {
        SP_KEEP,
        SP_INC,
        SP_DEC1,
        SP_DEC2,
        SP_POPN
    } sp_op_t;

    typedef enum logic [1:0] {
        VS_ZERO,
        VS_WORD,
        VS_BYTE
    } val_sel_t;

    typedef logic [UPC_W-1:0] upc_t;

    // one control word of the microprogram
    typedef struct packed {
        seq_op_t   seq;
        cond_t     cond;
        err_t      err;
        mem_op_t   mem;
        addr_sel_t addr;
        ld_t       ld;
        sp_op_t    sp;
        kind_t     kind;
        val_sel_t  vsel;
        upc_t      target;
    } ctl_t;

    // sequencer status toward the datapath
    typedef struct packed {
        logic       idle;
        logic       act;
        logic       first;
        logic       emit;
        logic [1:0] bidx;
    } seq_stat_t;

    // microprogram entry points
    localparam upc_t U_IDLE  = 6'd0;
    localparam upc_t U_LIT   = 6'd1;
    localparam upc_t U_LOAD  = 6'd4;
    localparam upc_t U_STORE = 6'd11;
    localparam upc_t U_ARITH = 6'd18;
    localparam upc_t U_PCHR  = 6'd24;
    localparam upc_t U_PC_RD = 6'd28;
    localparam upc_t U_PC_Z  = 6'd30;
    localparam upc_t U_PINT  = 6'd31;
    localparam upc_t U_NL    = 6'd34;

    function automatic ctl_t uop(seq_op_t seq, cond_t cond, err_t err, mem_op_t mem,
                                 addr_sel_t addr, ld_t ld, sp_op_t sp, kind_t kind,
                                 val_sel_t vsel, upc_t target);
        ctl_t c;
        c.seq    = seq;
        c.cond   = cond;
        c.err    = err;
        c.mem    = mem;
        c.addr   = addr;
        c.ld     = ld;
        c.sp     = sp;
        c.kind   = kind;
        c.vsel   = vsel;
        c.target = target;
        return c;
    endfunction

    // control store
    function automatic ctl_t ucode(upc_t upc);
        ctl_t c;
        case (upc)
            U_IDLE:
                c = uop(SQ_IDLE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            // literal
            U_LIT:
                c = uop(SQ_FAIL, CD_OVF, E_OVF, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LIT + 6'd1:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_WR, AS_SPP4, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LIT + 6'd2:
                c = uop(SQ_DONE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_INC,
                        K_ACK, VS_ZERO, U_IDLE);
            // load
            U_LOAD:
                c = uop(SQ_FAIL, CD_UND1, E_UNF, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LOAD + 6'd1:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LOAD + 6'd2:
                c = uop(SQ_FAIL, CD_ADDR, E_ADDR, MO_NONE, AS_SP, LD_TGT, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LOAD + 6'd3:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_TGT, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LOAD + 6'd4:
                c = uop(SQ_NEXT, CD_NONE, E_OK, MO_NONE, AS_SP, LD_WORD, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LOAD + 6'd5:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_WR, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_LOAD + 6'd6:
                c = uop(SQ_DONE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            // store
            U_STORE:
                c = uop(SQ_FAIL, CD_UND2, E_UNF, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_STORE + 6'd1:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_STORE + 6'd2:
                c = uop(SQ_FAIL, CD_ADDR, E_ADDR, MO_NONE, AS_SP, LD_TGT, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_STORE + 6'd3:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_SPM4, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_STORE + 6'd4:
                c = uop(SQ_NEXT, CD_NONE, E_OK, MO_NONE, AS_SP, LD_WORD, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_STORE + 6'd5:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_WR, AS_TGT, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_STORE + 6'd6:
                c = uop(SQ_DONE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_DEC2,
                        K_ACK, VS_ZERO, U_IDLE);
            // add and sub
            U_ARITH:
                c = uop(SQ_FAIL, CD_UND2, E_UNF, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_ARITH + 6'd1:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_ARITH + 6'd2:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_SPM4, LD_B, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_ARITH + 6'd3:
                c = uop(SQ_NEXT, CD_NONE, E_OK, MO_NONE, AS_SP, LD_ALU, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_ARITH + 6'd4:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_WR, AS_SPM4, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_ARITH + 6'd5:
                c = uop(SQ_DONE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_DEC1,
                        K_ACK, VS_ZERO, U_IDLE);
            // print chars
            U_PCHR:
                c = uop(SQ_FAIL, CD_UND1, E_UNF, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_PCHR + 6'd1:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_PCHR + 6'd2:
                c = uop(SQ_FAIL, CD_COUNT, E_UNF, MO_NONE, AS_SP, LD_CNT, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_PCHR + 6'd3:
                c = uop(SQ_SKIP, CD_ZERO, E_OK, MO_NONE, AS_SP, LD_NONE, SP_POPN,
                        K_ACK, VS_ZERO, U_PC_Z);
            U_PC_RD:
                c = uop(SQ_NEXT, CD_NONE, E_OK, MO_RD, AS_PTR, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_PC_RD + 6'd1:
                c = uop(SQ_CHAR, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_CHAR, VS_BYTE, U_PC_RD);
            U_PC_Z:
                c = uop(SQ_DONE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            // print int
            U_PINT:
                c = uop(SQ_FAIL, CD_UND1, E_UNF, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_PINT + 6'd1:
                c = uop(SQ_LOOP, CD_NONE, E_OK, MO_RD, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
            U_PINT + 6'd2:
                c = uop(SQ_DONE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_DEC1,
                        K_INT, VS_WORD, U_IDLE);
            // newline
            U_NL:
                c = uop(SQ_DONE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_NL, VS_ZERO, U_IDLE);
            default:
                c = uop(SQ_IDLE, CD_NONE, E_OK, MO_NONE, AS_SP, LD_NONE, SP_KEEP,
                        K_ACK, VS_ZERO, U_IDLE);
        endcase
        return c;
    endfunction

    // dispatch table
    function automatic upc_t entry(cmd_t cmd);
        upc_t u;
        case (cmd)
            CMD_LIT:   u = U_LIT;
            CMD_LOAD:  u = U_LOAD;
            CMD_STORE: u = U_STORE;
            CMD_ADD:   u = U_ARITH;
            CMD_SUB:   u = U_ARITH;
            CMD_PCHR:  u = U_PCHR;
            CMD_PINT:  u = U_PINT;
            CMD_NL:    u = U_NL;
            default:   u = U_IDLE;
        endcase
        return u;
    endfunction

endpackage

/* rtl/core/sbe_cmd_if.sv */
// instruction channel of the stack bytecode executor
// valid/ready handshake with command and immediate payload; no package dependency
interface sbe_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] immediate;

    modport source (output valid, output command, output immediate, input ready);
    modport sink (input valid, input command, input immediate, output ready);
endinterface

/* rtl/core/sbe_res_if.sv */
// result channel of the stack bytecode executor
// valid/ready handshake with kind, value, error and last payload; no package dependency
interface sbe_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [1:0]         error;
    logic               last;

    modport source (output valid, output kind, output value, output error, output last,
                    input ready);
    modport sink (input valid, input kind, input value, input error, input last,
                  output ready);
endinterface

/* rtl/core/sbe_seq.sv */
// microcode sequencer: step counter, byte loop counter and control store lookup
// depends on sbe_pkg for the control word, the microprogram and the dispatch table
module sbe_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sbe_pkg::cmd_t        cmd,
    input  logic                 cond,
    input  logic                 emit_ok,
    input  logic                 cnt_last,
    output sbe_pkg::ctl_t        ctl,
    output sbe_pkg::seq_stat_t   stat
);

    sbe_pkg::upc_t upc_reg;
    sbe_pkg::upc_t upc_next;
    logic [1:0]    bidx_reg;
    logic [1:0]    bidx_next;
    logic          emit_want;
    logic          stall;

    // step and byte counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= sbe_pkg::U_IDLE;
            bidx_reg <= 2'd0;
        end
        else
        begin
            upc_reg  <= upc_next;
            bidx_reg <= bidx_next;
        end
    end

    // control word, stall and next step
    always_comb
    begin
        ctl       = sbe_pkg::ucode(upc_reg);
        emit_want = (ctl.seq == sbe_pkg::SQ_DONE) || (ctl.seq == sbe_pkg::SQ_CHAR) ||
                    ((ctl.seq == sbe_pkg::SQ_FAIL) && cond);
        stall     = emit_want && !emit_ok;
        upc_next  = upc_reg;
        bidx_next = bidx_reg;
        case (ctl.seq)
            sbe_pkg::SQ_IDLE:
            begin
                if (start)
                begin
                    upc_next = sbe_pkg::entry(cmd);
                end
            end
            sbe_pkg::SQ_NEXT:
            begin
                upc_next = upc_reg + sbe_pkg::upc_t'(1);
            end
            sbe_pkg::SQ_LOOP:
            begin
                if (bidx_reg == 2'd3)
                begin
                    bidx_next = 2'd0;
                    upc_next  = upc_reg + sbe_pkg::upc_t'(1);
                end
                else
                begin
                    bidx_next = bidx_reg + 2'd1;
                end
            end
            sbe_pkg::SQ_FAIL:
            begin
                if (!stall)
                begin
                    upc_next = cond ? sbe_pkg::U_IDLE : upc_reg + sbe_pkg::upc_t'(1);
                end
            end
            sbe_pkg::SQ_SKIP:
            begin
                upc_next = cond ? ctl.target : upc_reg + sbe_pkg::upc_t'(1);
            end
            sbe_pkg::SQ_DONE:
            begin
                if (!stall)
                begin
                    upc_next = sbe_pkg::U_IDLE;
                end
            end
            sbe_pkg::SQ_CHAR:
            begin
                if (!stall)
                begin
                    upc_next = cnt_last ? sbe_pkg::U_IDLE : ctl.target;
                end
            end
            default:
            begin
                upc_next = sbe_pkg::U_IDLE;
            end
        endcase
        stat.idle  = (ctl.seq == sbe_pkg::SQ_IDLE);
        stat.act   = (ctl.seq != sbe_pkg::SQ_IDLE) && !stall;
        stat.first = (bidx_reg == 2'd0);
        stat.emit  = emit_want && emit_ok;
        stat.bidx  = bidx_reg;
    end

endmodule

/* rtl/core/stack_bytecode_executor.sv */
// Stack bytecode executor: runs one decoded stack-machine instruction per transaction.
// Instructions come in on instr (command, immediate); results leave on result (kind,
// value, error, last), one per instruction except print chars, which gives one
// character per word under the count, with last set on the final one (ack if 0).
// Configuration: cfg_we writes cfg_data into the stack size register (reset 128);
// the user must write it only while no instruction is in flight; not enforced here.
// Stack and data share one byte-wide memory; each word access is made byte by byte on
// its single port, and a microcoded sequencer steps through every instruction.
// An error ends the instruction at its failing check.
// The result sits in an output register; the next instruction is accepted while it
// waits, and the sequencer holds at its next emitting step while that result is unread.
// After reset the whole memory is cleared one byte per cycle, and instr.ready
// stays low until that pass ends; the stack is empty.
// depends on sbe_pkg, sbe_cmd_if, sbe_res_if and sbe_seq
module stack_bytecode_executor #(
    parameter int MEM_BYTES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    sbe_cmd_if.sink        instr,
    sbe_res_if.source      result,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_data
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [7:0]    LIM_CAP   = (MEM_BYTES < 256) ? 8'(MEM_BYTES) : 8'hFF;
    localparam logic [31:0]   ADDR_MAX  = 32'(MEM_BYTES - sbe_pkg::WORD_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
    localparam logic [7:0]    WB        = 8'(sbe_pkg::WORD_BYTES);

    sbe_pkg::ctl_t       ctl;
    sbe_pkg::seq_stat_t  stat;

    // control state
    logic                clr_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [7:0]          stack_bytes_reg;
    logic [7:0]          sp_reg;
    logic                rd_pend_reg;
    logic                out_valid_reg;

    // payload state
    logic [7:0]          ptr_reg;
    logic [sbe_pkg::CNT_W-1:0] cnt_reg;
    logic [AW-1:0]       tgt_reg;
    logic [31:0]         wr_word_reg;
    logic [31:0]         b_reg;
    logic [31:0]         acc_reg;
    logic [7:0]          rd_data_reg;
    sbe_pkg::cmd_t       cmd_reg;
    logic [1:0]          out_kind_reg;
    logic signed [31:0]  out_value_reg;
    logic [1:0]          out_error_reg;
    logic                out_last_reg;

    logic [7:0]          mem [MEM_BYTES];

    logic                accept;
    logic                emit_ok;
    logic                cnt_last;
    logic                cond;
    logic [31:0]         word_now;
    logic [31:0]         alu;
    logic [7:0]          limit;
    logic [5:0]          max_n;
    logic [7:0]          addr8;
    logic [AW-1:0]       op_addr;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic                mem_re;
    logic [7:0]          wr_byte;
    logic [7:0]          mem_wdata;
    logic                do_ld;
    logic [31:0]         out_value;

    assign accept   = instr.valid && instr.ready;
    assign emit_ok  = !out_valid_reg || result.ready;
    assign cnt_last = (cnt_reg == sbe_pkg::CNT_W'(1));

    sbe_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cmd      (sbe_pkg::cmd_t'(instr.command)),
        .cond     (cond),
        .emit_ok  (emit_ok),
        .cnt_last (cnt_last),
        .ctl      (ctl),
        .stat     (stat)
    );

    // assembled word: completes with the byte that arrives this cycle
    assign word_now = rd_pend_reg ? {acc_reg[23:0], rd_data_reg} : acc_reg;
    assign alu      = (cmd_reg == sbe_pkg::CMD_ADD) ? word_now + b_reg : word_now - b_reg;
    assign limit    = (stack_bytes_reg > LIM_CAP) ? LIM_CAP : stack_bytes_reg;
    assign max_n    = sp_reg[7:2] - 6'd1;

    // condition select
    always_comb
    begin
        case (ctl.cond)
            sbe_pkg::CD_OVF:   cond = ({1'b0, sp_reg} + 9'd8) > {1'b0, limit};
            sbe_pkg::CD_UND1:  cond = sp_reg < WB;
            sbe_pkg::CD_UND2:  cond = sp_reg < (WB + WB);
            sbe_pkg::CD_ADDR:  cond = word_now > ADDR_MAX;
            sbe_pkg::CD_COUNT: cond = word_now > {26'd0, max_n};
            sbe_pkg::CD_ZERO:  cond = (cnt_reg == '0);
            default:           cond = 1'b0;
        endcase
    end

    // byte address and write data
    always_comb
    begin
        case (ctl.addr)
            sbe_pkg::AS_SPM4: addr8 = sp_reg - WB + {6'd0, stat.bidx};
            sbe_pkg::AS_SPP4: addr8 = sp_reg + WB + {6'd0, stat.bidx};
            sbe_pkg::AS_PTR:  addr8 = ptr_reg + 8'd3;
            default:          addr8 = sp_reg + {6'd0, stat.bidx};
        endcase
        if (ctl.addr == sbe_pkg::AS_TGT)
        begin
            op_addr = tgt_reg + AW'(stat.bidx);
        end
        else
        begin
            op_addr = AW'(addr8);
        end
        case (stat.bidx)
            2'd0:    wr_byte = wr_word_reg[31:24];
            2'd1:    wr_byte = wr_word_reg[23:16];
            2'd2:    wr_byte = wr_word_reg[15:8];
            default: wr_byte = wr_word_reg[7:0];
        endcase
    end

    assign mem_we    = clr_reg || (stat.act && (ctl.mem == sbe_pkg::MO_WR));
    assign mem_re    = stat.act && (ctl.mem == sbe_pkg::MO_RD);
    assign mem_addr  = clr_reg ? clr_addr_reg : op_addr;
    assign mem_wdata = clr_reg ? 8'd0 : wr_byte;
    assign do_ld     = stat.act && stat.first;

    // byte memory, one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // clearing pass, configuration, stack pointer and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg         <= 1'b1;
            clr_addr_reg    <= '0;
            stack_bytes_reg <= 8'd128;
            sp_reg          <= 8'd0;
            rd_pend_reg     <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_we)
            begin
                stack_bytes_reg <= cfg_data;
            end
            if (stat.act)
            begin
                case (ctl.sp)
                    sbe_pkg::SP_INC:  sp_reg <= sp_reg + WB;
                    sbe_pkg::SP_DEC1: sp_reg <= sp_reg - WB;
                    sbe_pkg::SP_DEC2: sp_reg <= sp_reg - WB - WB;
                    sbe_pkg::SP_POPN: sp_reg <= sp_reg - {cnt_reg, 2'b00} - WB;
                    default:          sp_reg <= sp_reg;
                endcase
            end
            rd_pend_reg <= mem_re;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= sbe_pkg::cmd_t'(instr.command);
            wr_word_reg <= instr.immediate;
        end
        if (rd_pend_reg)
        begin
            acc_reg <= word_now;
        end
        if (do_ld)
        begin
            case (ctl.ld)
                sbe_pkg::LD_TGT:  tgt_reg     <= word_now[AW-1:0];
                sbe_pkg::LD_WORD: wr_word_reg <= word_now;
                sbe_pkg::LD_ALU:  wr_word_reg <= alu;
                sbe_pkg::LD_B:    b_reg       <= word_now;
                sbe_pkg::LD_CNT:  cnt_reg     <= word_now[sbe_pkg::CNT_W-1:0];
                default:          b_reg       <= b_reg;
            endcase
        end
        if (stat.act && (ctl.sp == sbe_pkg::SP_POPN))
        begin
            ptr_reg <= sp_reg - {cnt_reg, 2'b00};
        end
        if (mem_re && (ctl.addr == sbe_pkg::AS_PTR))
        begin
            ptr_reg <= ptr_reg + WB;
        end
        if (stat.emit && (ctl.seq == sbe_pkg::SQ_CHAR))
        begin
            cnt_reg <= cnt_reg - sbe_pkg::CNT_W'(1);
        end
    end

    // result value select
    always_comb
    begin
        case (ctl.vsel)
            sbe_pkg::VS_WORD: out_value = word_now;
            sbe_pkg::VS_BYTE: out_value = {24'd0, rd_data_reg};
            default:          out_value = 32'd0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.emit)
        begin
            out_kind_reg  <= ctl.kind;
            out_value_reg <= out_value;
            out_error_reg <= ctl.err;
            out_last_reg  <= (ctl.seq == sbe_pkg::SQ_CHAR) ? cnt_last : 1'b1;
        end
    end

    assign instr.ready  = stat.idle && !clr_reg;
    assign result.valid = out_valid_reg;
    assign result.kind  = out_kind_reg;
    assign result.value = out_value_reg;
    assign result.error = out_error_reg;
    assign result.last  = out_last_reg;

endmodule

/* rtl/core/sbe_chk.sv */
// port-level checker for the stack bytecode executor, bound to the top level
// depends on sbe_pkg for result kinds and error codes
module sbe_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [31:0] out_value,
    input logic [1:0]  out_error,
    input logic        out_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_value) &&
                                    $stable(out_error) && $stable(out_last))
        else $error("result payload changed while stalled");

    // an error answer is a lone acknowledge with zero value
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_error != sbe_pkg::E_OK) |->
            (out_kind == sbe_pkg::K_ACK) && (out_value == 32'd0) && out_last)
        else $error("malformed error result");

    // only character results come in runs
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != sbe_pkg::K_CHAR) |-> out_last)
        else $error("non-character result without last");

    // one instruction at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("instruction accepted while another executes");

endmodule

bind stack_bytecode_executor sbe_chk u_sbe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (instr.valid),
    .in_ready  (instr.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_kind  (result.kind),
    .out_value (result.value),
    .out_error (result.error),
    .out_last  (result.last)
);
